/* src/lprc_pkg.sv */
// Shared types and constants for the length-prefixed request checker.
package lprc_pkg;

	localparam int unsigned REQ_LEN_W = 32;
	localparam int unsigned ARG_CNT_W = 21;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQ_LEN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARGS    = 8'd1;

	localparam logic [REQ_LEN_W-1:0] RST_MAX_REQ_LEN = 32'd4096;
	localparam logic [ARG_CNT_W-1:0] RST_MAX_ARGS    = 21'd1024;

	typedef enum logic [2:0] {
		PH_LENGTH,
		PH_COUNT,
		PH_ARGHDR,
		PH_ARGDATA,
		PH_TAIL,
		PH_SKIP,
		PH_HALT
	} lprc_phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_TOO_MANY  = 3'd2,
		ST_NO_ARGS   = 3'd3,
		ST_MISSING   = 3'd4,
		ST_OVERRUN   = 3'd5,
		ST_TRAILING  = 3'd6,
		ST_TOO_LARGE = 3'd7
	} lprc_status_t;

	typedef struct packed {
		lprc_status_t           status;
		logic [ARG_CNT_W-1:0]   arg_count;
		logic [REQ_LEN_W-1:0]   req_len;
	} lprc_result_t;

endpackage

/* src/lprc_parser.sv */
// Front end: byte-wise request parser that produces at most one result per beat.
module lprc_parser import lprc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_fire,
	input  logic [7:0]           data_byte,
	input  logic [REQ_LEN_W-1:0] max_req_len,
	input  logic [ARG_CNT_W-1:0] max_args,
	output logic                 res_valid,
	output lprc_result_t         res
);

	lprc_phase_t          phase_q, phase_d;
	logic [1:0]           idx_q, idx_d;
	logic [23:0]          hdr_q, hdr_d;
	logic [REQ_LEN_W-1:0] len_q, len_d;
	logic [REQ_LEN_W-1:0] rem_q, rem_d;        // body bytes still to come
	logic [REQ_LEN_W-1:0] arg_bytes_q, arg_bytes_d;
	logic [ARG_CNT_W-1:0] args_left_q, args_left_d;
	logic [ARG_CNT_W-1:0] cnt_q, cnt_d;
	lprc_status_t         err_q, err_d;
	logic [REQ_LEN_W-1:0] field;
	logic                 field_done;
	logic                 finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LENGTH;
			idx_q   <= 2'd0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		hdr_q       <= hdr_d;
		len_q       <= len_d;
		rem_q       <= rem_d;
		arg_bytes_q <= arg_bytes_d;
		args_left_q <= args_left_d;
		cnt_q       <= cnt_d;
		err_q       <= err_d;
	end

	always_comb begin
		field       = {hdr_q, data_byte};
		field_done  = (idx_q == 2'd3);
		finish      = 1'b0;
		phase_d     = phase_q;
		idx_d       = idx_q;
		hdr_d       = hdr_q;
		len_d       = len_q;
		rem_d       = rem_q;
		arg_bytes_d = arg_bytes_q;
		args_left_d = args_left_q;
		cnt_d       = cnt_q;
		err_d       = err_q;
		res_valid   = 1'b0;
		res.status    = ST_OK;
		res.arg_count = '0;
		res.req_len   = len_q;

		if (byte_fire && phase_q == PH_LENGTH) begin
			idx_d = idx_q + 2'd1;
			hdr_d = field[23:0];
			if (field_done) begin
				if (field > max_req_len) begin
					// oversized: report once, then drop everything until reset
					res_valid     = 1'b1;
					res.status    = ST_TOO_LARGE;
					res.req_len   = field;
					phase_d       = PH_HALT;
				end else if (field == '0) begin
					res_valid     = 1'b1;
					res.status    = ST_SHORT;
					res.req_len   = '0;
				end else begin
					len_d   = field;
					rem_d   = field;
					cnt_d   = '0;
					err_d   = ST_OK;
					phase_d = PH_COUNT;
				end
			end
		end else if (byte_fire && phase_q != PH_HALT) begin
			rem_d = rem_q - 32'd1;
			unique case (phase_q)
				PH_COUNT: begin
					idx_d = idx_q + 2'd1;
					hdr_d = field[23:0];
					if (field_done) begin
						if (field > {11'd0, max_args}) begin
							err_d   = ST_TOO_MANY;
							phase_d = PH_SKIP;
						end else if (field == '0) begin
							err_d   = ST_NO_ARGS;
							phase_d = PH_SKIP;
						end else begin
							args_left_d = field[ARG_CNT_W-1:0];
							phase_d     = PH_ARGHDR;
						end
					end
				end
				PH_ARGHDR: begin
					idx_d = idx_q + 2'd1;
					hdr_d = field[23:0];
					if (field_done) begin
						// room after this byte is rem_q - 1, so size >= rem_q overruns
						if (field >= rem_q) begin
							err_d   = ST_OVERRUN;
							phase_d = PH_SKIP;
						end else if (field == '0) begin
							finish = 1'b1;
						end else begin
							arg_bytes_d = field;
							phase_d     = PH_ARGDATA;
						end
					end
				end
				PH_ARGDATA: begin
					arg_bytes_d = arg_bytes_q - 32'd1;
					finish      = (arg_bytes_q == 32'd1);
				end
				PH_TAIL: begin
					err_d   = ST_TRAILING;
					phase_d = PH_SKIP;
				end
				default: begin
				end
			endcase

			if (finish) begin
				cnt_d       = cnt_q + 21'd1;
				args_left_d = args_left_q - 21'd1;
				idx_d       = 2'd0;
				phase_d     = (args_left_q == 21'd1) ? PH_TAIL : PH_ARGHDR;
			end

			// last body byte: report and start over on the next prefix
			if (rem_q == 32'd1) begin
				res_valid     = 1'b1;
				res.arg_count = cnt_d;
				unique case (phase_d)
					PH_COUNT:   res.status = ST_SHORT;
					PH_ARGHDR:  res.status = ST_MISSING;
					PH_ARGDATA: res.status = ST_OVERRUN;
					PH_TAIL:    res.status = ST_OK;
					default:    res.status = err_d;
				endcase
				phase_d = PH_LENGTH;
				idx_d   = 2'd0;
			end
		end
	end

endmodule

/* src/lprc_queue.sv */
// Short result queue between the parser and the output stage.
module lprc_queue import lprc_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  lprc_result_t push_data,
	input  logic         pop,
	output lprc_result_t pop_data,
	output logic         empty,
	output logic         full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	lprc_result_t  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

/* src/lprc_out.sv */
// Back end: output register that drains the queue and holds a result under stall.
module lprc_out import lprc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	input  lprc_result_t q_data,
	output logic         q_pop,
	input  logic         out_ready,
	output logic         out_valid,
	output lprc_result_t out_res
);

	logic         valid_q;
	lprc_result_t res_q;

	assign q_pop     = !q_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			res_q <= q_data;
	end

endmodule

/* src/length_prefixed_request_checker_top.sv */
// Top level of the length-prefixed request checker.
//
// Input channel: one stream byte per beat on data_byte (in_valid/in_ready).
// Output channel: one result per request on status, argument_count and
// request_length (out_valid/out_ready), given after the last body byte, or
// straight after the fourth length byte for an empty or oversized body.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 max request length,
// 1 max argument count) and cfg_data; always ready, unknown indexes ignored.
// Throughput: one byte per cycle while the queue is not full. The parser
// updates its counters in the beat's own cycle and pushes the result into a
// small queue. The result of the last byte is written into the queue, then
// moved into the output register once the output side is free; out_valid
// comes from that register.
// Stall: while out_ready is low the output register holds its result and the
// queue fills; in_ready drops only once the queue is full.
// Reset: arst_n clears the parser to wait for a length prefix, empties the
// queue and output register, and restores the limits (4096 bytes, 1024 args).
// After an oversized length the parser drops every byte until reset.
module length_prefixed_request_checker_top import lprc_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [ARG_CNT_W-1:0] argument_count,
	output logic [REQ_LEN_W-1:0] request_length,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic [REQ_LEN_W-1:0] max_req_len_q;
	logic [ARG_CNT_W-1:0] max_args_q;
	logic                 byte_fire;
	logic                 res_valid;
	lprc_result_t         res;
	logic                 q_pop, q_empty, q_full;
	lprc_result_t         q_data;
	lprc_result_t         out_res;

	// limits register file
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_req_len_q <= RST_MAX_REQ_LEN;
			max_args_q    <= RST_MAX_ARGS;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_MAX_REQ_LEN)
				max_req_len_q <= cfg_data;
			else if (cfg_index == CFG_MAX_ARGS)
				max_args_q <= cfg_data[ARG_CNT_W-1:0];
		end
	end

	// a beat is taken whenever the queue has room for its possible result
	assign in_ready  = !q_full;
	assign byte_fire = in_valid && in_ready;

	lprc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_fire   (byte_fire),
		.data_byte   (data_byte),
		.max_req_len (max_req_len_q),
		.max_args    (max_args_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	lprc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	lprc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign status         = out_res.status;
	assign argument_count = out_res.arg_count;
	assign request_length = out_res.req_len;

`ifndef SYNTH
	// a result only ever comes from an accepted beat
	a_push_from_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (in_valid && in_ready))
		else $error("result pushed without an accepted beat");

	// while the queue holds a result, out_valid is high in the next cycle
	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |=> out_valid)
		else $error("queue holds a result but output is idle");

	// the output register never pops from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");
`endif

endmodule
